// ===== src/sensor_ema_validator_unit_defines.svh =====
// Assertion macros used by the checker file of the sensor EMA validator.
// No dependencies; include by bare file name.
`ifndef SENSOR_EMA_VALIDATOR_UNIT_DEFINES_SVH
`define SENSOR_EMA_VALIDATOR_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define SEVU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define SEVU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sevu_pkg.sv =====
// Shared types, widths and codes for the sensor EMA validator.
// No dependencies.
package sevu_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int HUM_WIDTH     = 14;
   localparam int TIME_WIDTH    = 32;
   localparam int STREAK_WIDTH  = 8;
   localparam int ALPHA_WIDTH   = 9;
   localparam int FRACTION_BITS = 8;
   localparam int ALPHA_SHIFT   = 8;      // alpha is in 1/256 units
   localparam int ALPHA_ONE     = 1 << ALPHA_SHIFT;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ALPHA        = 2'd0,
      CSR_TEMP_LOW     = 2'd1,
      CSR_TEMP_HIGH    = 2'd2,
      CSR_STREAK_LIMIT = 2'd3
   } csr_index_type;

   localparam logic [ALPHA_WIDTH-1:0]  ALPHA_RESET        = 9'd51;
   localparam logic [SAMPLE_WIDTH-1:0] TEMP_LOW_RESET     = 16'hF060;  // -4000
   localparam logic [SAMPLE_WIDTH-1:0] TEMP_HIGH_RESET    = 16'd12000;
   localparam logic [STREAK_WIDTH-1:0] STREAK_LIMIT_RESET = 8'd3;
   localparam logic [STREAK_WIDTH-1:0] STREAK_MAX         = '1;

   // Packed word layouts, lowest field first.
   localparam int REQ_DATA_WIDTH = 64;
   localparam int RSP_DATA_WIDTH = 72;
   localparam int RSP_TEMP_LSB   = 0;
   localparam int RSP_HUM_LSB    = RSP_TEMP_LSB + SAMPLE_WIDTH;
   localparam int RSP_ERR_BIT    = RSP_HUM_LSB + HUM_WIDTH;
   localparam int RSP_SINCE_LSB  = RSP_ERR_BIT + 1;
   localparam int RSP_STREAK_LSB = RSP_SINCE_LSB + TIME_WIDTH;
   localparam int RSP_ACC_BIT    = RSP_STREAK_LSB + STREAK_WIDTH;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]   now_ms;
      logic [HUM_WIDTH-1:0]    hum_sample;
      logic signed [SAMPLE_WIDTH-1:0] temp_sample;
      logic                    read_ok;
      logic                    device_present;
   } item_type;

   typedef struct packed {
      logic [STREAK_WIDTH-1:0]        streak_limit;
      logic signed [SAMPLE_WIDTH-1:0] temp_high;
      logic signed [SAMPLE_WIDTH-1:0] temp_low;
      logic [ALPHA_WIDTH-1:0]         alpha;
   } cfg_type;

   typedef struct packed {
      logic                           accepted;
      logic [STREAK_WIDTH-1:0]        bad_streak;
      logic [TIME_WIDTH-1:0]          error_since;
      logic                           sensor_error;
      logic [HUM_WIDTH-1:0]           hum_smoothed;
      logic signed [SAMPLE_WIDTH-1:0] temp_smoothed;
   } result_type;

endpackage

// ===== src/sevu_blend.sv =====
// One EMA blend step: avg + floor(alpha * (x - avg) / 256).
// Depends on sevu_pkg.
module sevu_blend #(
   parameter int AVG_WIDTH = 24
) (
   input  logic [sevu_pkg::ALPHA_WIDTH-1:0] alpha,     // already clamped to 0..256
   input  logic signed [AVG_WIDTH-1:0]      avg,
   input  logic signed [AVG_WIDTH-1:0]      sample,    // already scaled by 2^F
   output logic signed [AVG_WIDTH-1:0]      blended
);

   localparam int DIFF_WIDTH = AVG_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + sevu_pkg::ALPHA_WIDTH + 1;

   logic signed [DIFF_WIDTH-1:0]  diff;
   logic signed [sevu_pkg::ALPHA_WIDTH:0] alpha_s;
   logic signed [PROD_WIDTH-1:0]  prod;
   logic signed [PROD_WIDTH-1:0]  step;

   // 256*avg is divisible by 256, so flooring only the product is exact.
   assign diff    = DIFF_WIDTH'(sample) - DIFF_WIDTH'(avg);
   assign alpha_s = $signed({1'b0, alpha});
   assign prod    = PROD_WIDTH'(alpha_s) * PROD_WIDTH'(diff);
   assign step    = prod >>> sevu_pkg::ALPHA_SHIFT;
   assign blended = avg + step[AVG_WIDTH-1:0];

endmodule

// ===== src/sevu_update.sv =====
// Validator state (link, error latch, streak, averages) and its update for
// one read attempt. Depends on sevu_pkg and sevu_blend.
module sevu_update #(
   parameter int FRACTION_BITS = sevu_pkg::FRACTION_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  sevu_pkg::item_type   item,
   input  sevu_pkg::cfg_type    cfg,
   output sevu_pkg::result_type result
);

   localparam int TEMP_AVG_W = sevu_pkg::SAMPLE_WIDTH + FRACTION_BITS;
   localparam int HUM_AVG_W  = sevu_pkg::HUM_WIDTH + 1 + FRACTION_BITS;

   logic                                linked_ff, linked_in;
   logic                                first_ff, first_in;
   logic signed [TEMP_AVG_W-1:0]        temp_avg_ff, temp_avg_in;
   logic signed [HUM_AVG_W-1:0]         hum_avg_ff, hum_avg_in;
   logic [sevu_pkg::STREAK_WIDTH-1:0]   streak_ff, streak_in;
   logic                                err_ff, err_in;
   logic [sevu_pkg::TIME_WIDTH-1:0]     err_time_ff, err_time_in;

   logic [sevu_pkg::ALPHA_WIDTH-1:0]    alpha_eff;
   logic signed [TEMP_AVG_W-1:0]        temp_scaled, temp_blend;
   logic signed [HUM_AVG_W-1:0]         hum_scaled, hum_blend;
   logic                                in_window;
   logic                                acc;

   assign alpha_eff = (cfg.alpha > sevu_pkg::ALPHA_WIDTH'(sevu_pkg::ALPHA_ONE))
                      ? sevu_pkg::ALPHA_WIDTH'(sevu_pkg::ALPHA_ONE) : cfg.alpha;

   assign temp_scaled = {item.temp_sample, {FRACTION_BITS{1'b0}}};
   assign hum_scaled  = {1'b0, item.hum_sample, {FRACTION_BITS{1'b0}}};
   assign in_window   = (item.temp_sample > cfg.temp_low)
                        && (item.temp_sample < cfg.temp_high);

   sevu_blend #(.AVG_WIDTH(TEMP_AVG_W)) u_temp_blend (
      .alpha   (alpha_eff),
      .avg     (temp_avg_ff),
      .sample  (temp_scaled),
      .blended (temp_blend)
   );

   sevu_blend #(.AVG_WIDTH(HUM_AVG_W)) u_hum_blend (
      .alpha   (alpha_eff),
      .avg     (hum_avg_ff),
      .sample  (hum_scaled),
      .blended (hum_blend)
   );

   always_comb begin
      logic go;
      logic latch;
      go          = 1'b1;
      latch       = 1'b0;
      acc         = 1'b0;
      linked_in   = linked_ff;
      first_in    = first_ff;
      temp_avg_in = temp_avg_ff;
      hum_avg_in  = hum_avg_ff;
      streak_in   = streak_ff;
      err_in      = err_ff;
      err_time_in = err_time_ff;

      if (!linked_ff) begin
         if (item.device_present) begin
            linked_in = 1'b1;
            err_in    = 1'b0;
            streak_in = '0;
         end else begin
            latch = 1'b1;
            go    = 1'b0;
         end
      end

      if (go) begin
         if (!item.read_ok) begin
            latch = 1'b1;
         end else if (in_window) begin
            streak_in = '0;
            err_in    = 1'b0;
            acc       = 1'b1;
            first_in  = 1'b0;
            if (first_ff) begin
               temp_avg_in = temp_scaled;
               hum_avg_in  = hum_scaled;
            end else begin
               temp_avg_in = temp_blend;
               hum_avg_in  = hum_blend;
            end
         end else begin
            if (streak_in != sevu_pkg::STREAK_MAX) begin
               streak_in = streak_in + 1'b1;
            end
            if (streak_in >= cfg.streak_limit) begin
               latch = 1'b1;
            end
         end
      end

      // error time is only taken on a clear-to-set transition
      if (latch && !err_in) begin
         err_in      = 1'b1;
         err_time_in = item.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         linked_ff   <= 1'b0;
         first_ff    <= 1'b1;
         temp_avg_ff <= '0;
         hum_avg_ff  <= '0;
         streak_ff   <= '0;
         err_ff      <= 1'b0;
         err_time_ff <= '0;
      end else if (step_en) begin
         linked_ff   <= linked_in;
         first_ff    <= first_in;
         temp_avg_ff <= temp_avg_in;
         hum_avg_ff  <= hum_avg_in;
         streak_ff   <= streak_in;
         err_ff      <= err_in;
         err_time_ff <= err_time_in;
      end
   end

   // Result reflects the state after this item's update.
   assign result.temp_smoothed = temp_avg_in[FRACTION_BITS +: sevu_pkg::SAMPLE_WIDTH];
   assign result.hum_smoothed  = hum_avg_in[FRACTION_BITS +: sevu_pkg::HUM_WIDTH];
   assign result.sensor_error  = err_in;
   assign result.error_since   = err_time_in;
   assign result.bad_streak    = streak_in;
   assign result.accepted      = acc;

endmodule

// ===== src/sensor_ema_validator_unit.sv =====
// Top level of the sensor EMA validator: stream ports, config registers,
// input and result registers. Depends on sevu_pkg and sevu_update.

// One read attempt per word on req_, one result word per attempt on rsp_.
// The block takes a new word every cycle while rsp_ is not stalled: a word is
// registered on accept, the state update and result are computed from it
// combinationally, and the result is loaded into the output register when the
// held word advances, which raises rsp_tvalid. Throughput is one word per
// clock while rsp_tready keeps up; each average uses one multiply, 9x25 for
// temperature and 9x24 for humidity. While the output register holds an
// untaken result, req_tready stays high only until the input register fills.
// Averages carry FRACTION_BITS fraction bits. Config registers are written
// through csr_ by the user only while idle; the block does not enforce this.
module sensor_ema_validator_unit #(
   parameter int FRACTION_BITS = sevu_pkg::FRACTION_BITS
) (
   input  logic clock,
   input  logic reset,
   // device_present[0], read_ok[1], temp_sample[17:2], hum_sample[31:18],
   // now_ms[63:32]
   input  logic [sevu_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // temp_smoothed[15:0], hum_smoothed[29:16], sensor_error[30],
   // error_since[62:31], bad_streak[70:63], accepted[71]
   output logic [sevu_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sevu_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sevu_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   sevu_pkg::cfg_type    cfg_ff;
   sevu_pkg::item_type   item_ff;
   logic                 item_vld_ff;
   sevu_pkg::result_type rsp_ff, result;
   logic                 rsp_vld_ff;
   logic                 advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha        <= sevu_pkg::ALPHA_RESET;
         cfg_ff.temp_low     <= sevu_pkg::TEMP_LOW_RESET;
         cfg_ff.temp_high    <= sevu_pkg::TEMP_HIGH_RESET;
         cfg_ff.streak_limit <= sevu_pkg::STREAK_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (sevu_pkg::csr_index_type'(csr_index))
            sevu_pkg::CSR_ALPHA: begin
               cfg_ff.alpha <= csr_data[sevu_pkg::ALPHA_WIDTH-1:0];
            end
            sevu_pkg::CSR_TEMP_LOW: begin
               cfg_ff.temp_low <= csr_data[sevu_pkg::SAMPLE_WIDTH-1:0];
            end
            sevu_pkg::CSR_TEMP_HIGH: begin
               cfg_ff.temp_high <= csr_data[sevu_pkg::SAMPLE_WIDTH-1:0];
            end
            sevu_pkg::CSR_STREAK_LIMIT: begin
               cfg_ff.streak_limit <= csr_data[sevu_pkg::STREAK_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The held word moves on whenever the result register is free or draining.
   assign advance    = item_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !item_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_tready) begin
         item_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= sevu_pkg::item_type'(req_tdata);
      end
   end

   sevu_update #(.FRACTION_BITS(FRACTION_BITS)) u_update (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

// ===== src/sevu_checker.sv =====
// Port-level checks for the sensor EMA validator, bound to the top level.
// Depends on sevu_pkg and sensor_ema_validator_unit_defines.svh.
`include "sensor_ema_validator_unit_defines.svh"

module sevu_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic [sevu_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready
);

   logic                                rsp_acc;
   logic                                rsp_err;
   logic [sevu_pkg::STREAK_WIDTH-1:0]   rsp_streak;

   assign rsp_acc    = rsp_tdata[sevu_pkg::RSP_ACC_BIT];
   assign rsp_err    = rsp_tdata[sevu_pkg::RSP_ERR_BIT];
   assign rsp_streak = rsp_tdata[sevu_pkg::RSP_STREAK_LSB +: sevu_pkg::STREAK_WIDTH];

   // a stalled result word holds
   `SEVU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")

   // an accepted sample always clears the error latch
   `SEVU_ASSERT_NOW(a_acc_no_err, clock, reset, rsp_tvalid && rsp_acc,
      !rsp_err, "accepted sample reported with error set")

   // an accepted sample always clears the streak
   `SEVU_ASSERT_NOW(a_acc_streak, clock, reset, rsp_tvalid && rsp_acc,
      rsp_streak == '0, "accepted sample reported with nonzero streak")

   // with the result register empty nothing may back-pressure the input
   `SEVU_ASSERT_NOW(a_ready_empty, clock, reset, !rsp_tvalid,
      req_tready, "input stalled while result register is empty")

endmodule

bind sensor_ema_validator_unit sevu_checker u_sevu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ===== tb/sensor_ema_validator_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sensor_ema_validator_unit: streams sensor read words,
// tracks the expected filter state and checks every result word.
// Depends on sevu_pkg and the RTL under src.
module sensor_ema_validator_unit_tb;

   typedef logic signed [sevu_pkg::SAMPLE_WIDTH+sevu_pkg::FRACTION_BITS-1:0] ema_type;

   typedef struct {
      sevu_pkg::item_type   stim;
      bit                   pinned;
      sevu_pkg::result_type want;
   } script_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic [sevu_pkg::REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [sevu_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [sevu_pkg::CSR_INDEX_WIDTH-1:0] csr_index = sevu_pkg::CSR_ALPHA;
   logic [sevu_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   sensor_ema_validator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // filter state as the block should hold it
   sevu_pkg::cfg_type                 cfg;
   bit                                link_up;
   bit                                seed_pending;
   bit                                err_latched;
   ema_type                           temp_avg;
   ema_type                           hum_avg;
   logic [sevu_pkg::STREAK_WIDTH-1:0] streak;
   logic [sevu_pkg::TIME_WIDTH-1:0]   err_time;

   sevu_pkg::result_type            pending_readings[$];
   int                              faults = 0;
   int                              words_checked = 0;
   int                              items_sent = 0;
   int                              settings_used = 1;
   bit                              idle_on = 1'b1;
   int                              stall_left = 0;
   logic [sevu_pkg::TIME_WIDTH-1:0] wall_ms = '0;

   function automatic void latch_fault(logic [sevu_pkg::TIME_WIDTH-1:0] now);
      if (!err_latched) begin
         err_latched = 1'b1;
         err_time    = now;
      end
   endfunction

   // avg' = floor((a*x*256 + (256-a)*avg) / 256), a saturated at 256
   function automatic ema_type ema_blend(ema_type avg, longint sample);
      longint w;
      longint sum;
      w   = (cfg.alpha > 9'd256) ? 64'sd256 : longint'(cfg.alpha);
      sum = w * (sample <<< sevu_pkg::FRACTION_BITS) + (64'sd256 - w) * longint'(avg);
      return ema_type'(sum >>> sevu_pkg::ALPHA_SHIFT);
   endfunction

   function automatic sevu_pkg::result_type track_sensor(sevu_pkg::item_type it);
      sevu_pkg::result_type r;
      int                   t;
      int                   lo;
      int                   hi;
      bit                   reading;
      bit                   took;
      t       = $signed(it.temp_sample);
      lo      = $signed(cfg.temp_low);
      hi      = $signed(cfg.temp_high);
      reading = 1'b1;
      took    = 1'b0;
      if (!link_up) begin
         if (it.device_present) begin
            link_up     = 1'b1;
            err_latched = 1'b0;
            streak      = '0;
         end else begin
            latch_fault(it.now_ms);
            reading = 1'b0;
         end
      end
      if (reading) begin
         if (!it.read_ok) begin
            latch_fault(it.now_ms);
         end else if (t > lo && t < hi) begin
            streak = '0;
            if (seed_pending) begin
               temp_avg     = ema_type'(longint'(t) <<< sevu_pkg::FRACTION_BITS);
               hum_avg      = ema_type'(longint'(it.hum_sample) <<< sevu_pkg::FRACTION_BITS);
               seed_pending = 1'b0;
            end else begin
               temp_avg = ema_blend(temp_avg, longint'(t));
               hum_avg  = ema_blend(hum_avg, longint'(it.hum_sample));
            end
            err_latched = 1'b0;
            took        = 1'b1;
         end else begin
            if (streak != sevu_pkg::STREAK_MAX) streak = streak + 1'b1;
            if (streak >= cfg.streak_limit) latch_fault(it.now_ms);
         end
      end
      r.temp_smoothed = temp_avg[sevu_pkg::FRACTION_BITS +: sevu_pkg::SAMPLE_WIDTH];
      r.hum_smoothed  = hum_avg[sevu_pkg::FRACTION_BITS +: sevu_pkg::HUM_WIDTH];
      r.sensor_error  = err_latched;
      r.error_since   = err_time;
      r.bad_streak    = streak;
      r.accepted      = took;
      return r;
   endfunction

   function automatic sevu_pkg::item_type reading_in(bit present, bit ok, int temp, int hum,
                                                     logic [sevu_pkg::TIME_WIDTH-1:0] now);
      sevu_pkg::item_type it;
      it.device_present = present;
      it.read_ok        = ok;
      it.temp_sample    = temp[sevu_pkg::SAMPLE_WIDTH-1:0];
      it.hum_sample     = hum[sevu_pkg::HUM_WIDTH-1:0];
      it.now_ms         = now;
      return it;
   endfunction

   function automatic sevu_pkg::result_type reading_out(int temp, int hum, bit err,
                                                        logic [sevu_pkg::TIME_WIDTH-1:0] since,
                                                        int cnt, bit took);
      sevu_pkg::result_type r;
      r.temp_smoothed = temp[sevu_pkg::SAMPLE_WIDTH-1:0];
      r.hum_smoothed  = hum[sevu_pkg::HUM_WIDTH-1:0];
      r.sensor_error  = err;
      r.error_since   = since;
      r.bad_streak    = cnt[sevu_pkg::STREAK_WIDTH-1:0];
      r.accepted      = took;
      return r;
   endfunction

   // mostly in-window temperatures, some right at the bounds, some anywhere
   function automatic sevu_pkg::item_type random_reading(int fail_pct);
      sevu_pkg::item_type it;
      int                 lo;
      int                 hi;
      int                 t;
      int                 pick;
      lo   = $signed(cfg.temp_low);
      hi   = $signed(cfg.temp_high);
      pick = $urandom_range(0, 9);
      if (hi - lo > 1 && pick < 6) t = lo + 1 + int'($urandom_range(0, hi - lo - 2));
      else if (pick < 8) t = (pick[0] ? lo : hi) + int'($urandom_range(0, 2)) - 1;
      else t = $urandom;
      wall_ms = wall_ms + $urandom_range(1, 5000);
      it.device_present = 1'($urandom_range(0, 1));
      it.read_ok        = $urandom_range(1, 100) > fail_pct;
      it.temp_sample    = t[sevu_pkg::SAMPLE_WIDTH-1:0];
      it.hum_sample     = ($urandom_range(0, 4) == 0) ? 14'($urandom_range(0, 16383))
                                                      : 14'($urandom_range(0, 10000));
      it.now_ms         = ($urandom_range(0, 9) == 0) ? $urandom : wall_ms;
      return it;
   endfunction

   task automatic send_reading(sevu_pkg::item_type it, bit pinned,
                               sevu_pkg::result_type want);
      sevu_pkg::result_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tdata  <= it;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = track_sensor(it);
      pending_readings.push_back(pinned ? want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_block;
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // all four registers back to back, valid held high across them
   task automatic program_filter(logic [sevu_pkg::ALPHA_WIDTH-1:0] alpha, int lo, int hi,
                                 logic [sevu_pkg::STREAK_WIDTH-1:0] limit);
      sevu_pkg::csr_index_type             idx;
      logic [sevu_pkg::CSR_DATA_WIDTH-1:0] value;
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         idx = sevu_pkg::csr_index_type'(i);
         case (idx)
            sevu_pkg::CSR_ALPHA:     value = {7'($urandom), alpha};
            sevu_pkg::CSR_TEMP_LOW:  value = lo[sevu_pkg::CSR_DATA_WIDTH-1:0];
            sevu_pkg::CSR_TEMP_HIGH: value = hi[sevu_pkg::CSR_DATA_WIDTH-1:0];
            default:                 value = {8'($urandom), limit};
         endcase
         csr_index <= idx;
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
         case (idx)
            sevu_pkg::CSR_ALPHA:     cfg.alpha     = value[sevu_pkg::ALPHA_WIDTH-1:0];
            sevu_pkg::CSR_TEMP_LOW:  cfg.temp_low  = value;
            sevu_pkg::CSR_TEMP_HIGH: cfg.temp_high = value;
            default: cfg.streak_limit = value[sevu_pkg::STREAK_WIDTH-1:0];
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(logic [sevu_pkg::ALPHA_WIDTH-1:0] alpha, int lo, int hi,
                            logic [sevu_pkg::STREAK_WIDTH-1:0] limit, int count,
                            int fail_pct);
      drain_block();
      program_filter(alpha, lo, hi, limit);
      repeat (count) send_reading(random_reading(fail_pct), 1'b0, '0);
   endtask

   // receiver stalls in bursts, started at random while idle_on is set
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      sevu_pkg::result_type got;
      sevu_pkg::result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_readings.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%t: result word with none expected: %h", $time, rsp_tdata);
         end else begin
            exp = pending_readings.pop_front();
            words_checked++;
            if (got !== exp) begin
               faults++;
               if (faults <= 10) begin
                  $display("%t: mismatch (exp/got) temp %0d/%0d hum %0d/%0d err %b/%b",
                           $time, exp.temp_smoothed, got.temp_smoothed,
                           exp.hum_smoothed, got.hum_smoothed,
                           exp.sensor_error, got.sensor_error);
                  $display("   since %0d/%0d streak %0d/%0d acc %b/%b",
                           exp.error_since, got.error_since, exp.bad_streak,
                           got.bad_streak, exp.accepted, got.accepted);
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("sensor_ema_validator_unit_tb: FAIL");
      $finish;
   end

   initial begin
      script_row_type script[$];
      int             lo;
      cfg.alpha        = sevu_pkg::ALPHA_RESET;
      cfg.temp_low     = sevu_pkg::TEMP_LOW_RESET;
      cfg.temp_high    = sevu_pkg::TEMP_HIGH_RESET;
      cfg.streak_limit = sevu_pkg::STREAK_LIMIT_RESET;
      link_up      = 1'b0;
      seed_pending = 1'b1;
      err_latched  = 1'b0;
      temp_avg     = '0;
      hum_avg      = '0;
      streak       = '0;
      err_time     = '0;

      // reset window (-4000, 12000), limit 3; pinned rows are easy to read off
      // absent device latches, second absence keeps the first time
      script.push_back('{reading_in(0, 1, 1234, 100, 1000), 1'b1,
                         reading_out(0, 0, 1, 1000, 0, 0)});
      script.push_back('{reading_in(0, 0, -5, 7, 2000), 1'b1,
                         reading_out(0, 0, 1, 1000, 0, 0)});
      // reconnect clears, then the failed read latches again
      script.push_back('{reading_in(1, 0, 0, 0, 3000), 1'b1,
                         reading_out(0, 0, 1, 3000, 0, 0)});
      // first good sample seeds the averages
      script.push_back('{reading_in(1, 1, 2500, 5000, 4000), 1'b1,
                         reading_out(2500, 5000, 0, 3000, 0, 1)});
      // link stays up with device absent; same sample blends to itself
      script.push_back('{reading_in(0, 1, 2500, 5000, 5000), 1'b1,
                         reading_out(2500, 5000, 0, 3000, 0, 1)});
      // bounds are exclusive; streak of 3 latches
      script.push_back('{reading_in(1, 1, -4000, 9999, 6000), 1'b1,
                         reading_out(2500, 5000, 0, 3000, 1, 0)});
      script.push_back('{reading_in(1, 1, 12000, 1, 7000), 1'b1,
                         reading_out(2500, 5000, 0, 3000, 2, 0)});
      script.push_back('{reading_in(1, 1, -32768, 16383, 8000), 1'b1,
                         reading_out(2500, 5000, 1, 8000, 3, 0)});
      script.push_back('{reading_in(1, 1, 32767, 0, 9000), 1'b1,
                         reading_out(2500, 5000, 1, 8000, 4, 0)});
      // failed read leaves the streak alone
      script.push_back('{reading_in(1, 0, 100, 100, 10000), 1'b1,
                         reading_out(2500, 5000, 1, 8000, 4, 0)});
      script.push_back('{reading_in(1, 1, -3999, 0, 11000), 1'b0, '0});
      script.push_back('{reading_in(1, 1, 11999, 16383, 12000), 1'b0, '0});
      script.push_back('{reading_in(1, 1, 0, 10000, 13000), 1'b0, '0});
      script.push_back('{reading_in(1, 1, -1, 1, 32'hFFFF_FFFF), 1'b0, '0});
      script.push_back('{reading_in(1, 0, -1, 16383, 0), 1'b0, '0});
      script.push_back('{reading_in(1, 1, 12001, 0, 32'h8000_0000), 1'b0, '0});
      script.push_back('{reading_in(1, 1, -4001, 77, 32'h0000_FFFF), 1'b0, '0});
      script.push_back('{reading_in(1, 1, -3000, 3000, 32'h1234_5678), 1'b0, '0});
      script.push_back('{reading_in(1, 0, -32768, 8192, 32'h5555_5555), 1'b0, '0});
      script.push_back('{reading_in(1, 1, 11000, 2, 32'hAAAA_AAAA), 1'b0, '0});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_reading(script[i].stim, script[i].pinned, script[i].want);

      // full alpha, widest window, latch on first bad sample
      run_phase(9'd256, -32768, 32767, 8'd1, 80, 10);
      // zero alpha holds the averages; limit zero
      run_phase(9'd0, -1000, 3000, 8'd0, 70, 10);
      // empty window with alpha over range: streak runs into saturation
      run_phase(9'd511, 100, 100, 8'd255, 290, 2);
      lo = -int'($urandom_range(0, 5000));
      run_phase(9'($urandom_range(1, 255)), lo, $urandom_range(0, 8000),
                8'($urandom_range(1, 20)), 100, 10);
      // back to reset settings, no idling on either side
      idle_on = 1'b0;
      run_phase(sevu_pkg::ALPHA_RESET, $signed(sevu_pkg::TEMP_LOW_RESET),
                $signed(sevu_pkg::TEMP_HIGH_RESET), sevu_pkg::STREAK_LIMIT_RESET,
                100, 10);

      drain_block();
      repeat (10) @(negedge clock);

      $display("sent %0d read words over %0d filter settings, checked %0d result words",
               items_sent, settings_used, words_checked);
      $display("covered reconnect, seeding, blend, window edges, streak latch and saturation");
      if (faults == 0) begin
         $display("sensor_ema_validator_unit_tb: PASS");
      end else begin
         $display("%0d failing words", faults);
         $display("sensor_ema_validator_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/sevu_pkg.sv
src/sevu_blend.sv
src/sevu_update.sv
src/sensor_ema_validator_unit.sv
src/sevu_checker.sv
tb/sensor_ema_validator_unit_tb.sv
